/* sv/wim_pkg.sv */
// wim_pkg: shared constants, types and arithmetic helpers for the weighted
// image moments block. Used by every module of the block; depends on nothing.

package wim_pkg;

    // Geometry and storage
    localparam int INDEX_BITS    = 9;
    localparam int MAX_CONTRASTS = 4;
    localparam int CONTRAST_W    = 2;
    localparam int INTENS_W      = 16;
    localparam int NUM_AXES      = 3;
    localparam int NUM_PAIRS     = 6;
    localparam int NUM_SUMS      = 1 + NUM_AXES + NUM_PAIRS;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = QPTR_W + 1;
    localparam int NUM_STAGES    = 5;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int CEN_CFG_W = 48;
    localparam int FIELD_W   = 16;

    // Datapath widths
    localparam int COEF_W   = 16;
    localparam int IDXS_W   = INDEX_BITS + 1;
    localparam int PROD_W   = COEF_W + IDXS_W;
    localparam int CSUM_W   = PROD_W + 2;
    localparam int CRD_SH   = 6;
    localparam int CRD_HALF = 1 << (CRD_SH - 1);
    localparam int CRD_W    = CSUM_W - CRD_SH + 1;
    localparam int CEN_W    = CRD_W + 1;
    localparam int WPROD_W  = INTENS_W + FIELD_W + 1;
    localparam int V_SH     = 12;
    localparam int V_HALF   = 1 << (V_SH - 1);
    localparam int V_W      = WPROD_W - V_SH;
    localparam int FIRST_W  = CRD_W + V_W;
    localparam int PP_W     = 2 * CEN_W;
    localparam int LO_W     = PP_W / 2;
    localparam int HI_W     = PP_W - LO_W;
    localparam int PLO_W    = LO_W + 1 + V_W;
    localparam int PHI_W    = HI_W + V_W;
    localparam int TERM_W   = PP_W + V_W + 1;
    localparam int WIDE_W   = (TERM_W > 65) ? TERM_W : 65;
    localparam int SUM_W    = 64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Reset values of the registers
    localparam logic [CFG_W-1:0]     RST_ROW_X   = 64'h0000_0000_0000_0100;
    localparam logic [CFG_W-1:0]     RST_ROW_Y   = 64'h0000_0000_0100_0000;
    localparam logic [CFG_W-1:0]     RST_ROW_Z   = 64'h0000_0100_0000_0000;
    localparam logic [CEN_CFG_W-1:0] RST_CENTRE  = '0;
    localparam logic [CFG_W-1:0]     RST_WEIGHTS = 64'h1000_1000_1000_1000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AFFINE_X = 3'd0,
        REG_AFFINE_Y = 3'd1,
        REG_AFFINE_Z = 3'd2,
        REG_CENTRE   = 3'd3,
        REG_WEIGHTS  = 3'd4
    } t_cfg_reg;

    // Axis codes and the axis pairs of the second moments (xy yz xz xx yy zz)
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    localparam t_axis PAIR_A [NUM_PAIRS] = '{AXIS_X, AXIS_Y, AXIS_X, AXIS_X, AXIS_Y, AXIS_Z};
    localparam t_axis PAIR_B [NUM_PAIRS] = '{AXIS_Y, AXIS_Z, AXIS_Z, AXIS_X, AXIS_Y, AXIS_Z};

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [CFG_W-1:0]     row_x;
        logic [CFG_W-1:0]     row_y;
        logic [CFG_W-1:0]     row_z;
        logic [CEN_CFG_W-1:0] centre;
        logic [CFG_W-1:0]     weights;
    } t_cfg;

    typedef struct packed {
        logic [INDEX_BITS-1:0]      idx_i;
        logic [INDEX_BITS-1:0]      idx_j;
        logic [INDEX_BITS-1:0]      idx_k;
        logic [CONTRAST_W-1:0]      contrast;
        logic signed [INTENS_W-1:0] intensity;
        logic                       take;
        logic                       last;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Q8.8 affine row times grid index, before rounding
    function automatic logic signed [CSUM_W-1:0] coord_sum(
        input logic [CFG_W-1:0]      row,
        input logic [INDEX_BITS-1:0] i,
        input logic [INDEX_BITS-1:0] j,
        input logic [INDEX_BITS-1:0] k
    );
        logic signed [COEF_W-1:0] ci, cj, ck;
        logic signed [IDXS_W-1:0] si, sj, sk;
        logic signed [PROD_W-1:0] pi, pj, pk;
        ci = row[15:0];
        cj = row[31:16];
        ck = row[47:32];
        si = {1'b0, i};
        sj = {1'b0, j};
        sk = {1'b0, k};
        pi = ci * si;
        pj = cj * sj;
        pk = ck * sk;
        return CSUM_W'(pi) + CSUM_W'(pj) + CSUM_W'(pk);
    endfunction

    // Clamp a wide signed value to the 64-bit range
    function automatic t_sum sat64(input logic signed [WIDE_W-1:0] a);
        if ((&a[WIDE_W-1:SUM_W-1]) || !(|a[WIDE_W-1:SUM_W-1]))
            return a[SUM_W-1:0];
        else if (a[WIDE_W-1])
            return SUM_MIN;
        else
            return SUM_MAX;
    endfunction

    // Saturating 64-bit add
    function automatic t_sum sat_add(input t_sum a, input t_sum b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            return s[SUM_W-1:0];
    endfunction

endpackage

/* sv/weighted_image_moments.sv */
// weighted_image_moments: top level with the configuration registers, joining
// front, queue and back end. Depends on wim_pkg, wim_front, wim_queue, wim_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready   | index_i/j/k, contrast, intensity, flags
//  result   | o_out_valid / i_out_ready | ten 64-bit moment sums
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One input beat per cycle while the queue is not full; the last item of an image
// passes the queue and the five stages before its result sits in the output register.
// Reset is synchronous; sums, queue and pipeline clear at once, no clearing pass.
// A held result stalls the pipeline; the four-entry queue keeps taking beats until full.
// Configuration beats are taken only while queue and pipeline are empty.

module weighted_image_moments
    import wim_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [INDEX_BITS-1:0]      i_index_i,
    input  logic [INDEX_BITS-1:0]      i_index_j,
    input  logic [INDEX_BITS-1:0]      i_index_k,
    input  logic [CONTRAST_W-1:0]      i_contrast_index,
    input  logic signed [INTENS_W-1:0] i_intensity,
    input  logic                       i_in_mask,
    input  logic                       i_sample_finite,
    input  logic                       i_last_voxel,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SUM_W-1:0]    o_mass_sum,
    output logic signed [SUM_W-1:0]    o_first_x,
    output logic signed [SUM_W-1:0]    o_first_y,
    output logic signed [SUM_W-1:0]    o_first_z,
    output logic signed [SUM_W-1:0]    o_second_xy,
    output logic signed [SUM_W-1:0]    o_second_yz,
    output logic signed [SUM_W-1:0]    o_second_xz,
    output logic signed [SUM_W-1:0]    o_second_xx,
    output logic signed [SUM_W-1:0]    o_second_yy,
    output logic signed [SUM_W-1:0]    o_second_zz,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    t_cfg      r_cfg;
    t_q_status q_status;
    t_item     push_item;
    t_item     head_item;
    logic      push;
    logic      pop;
    logic      back_busy;
    t_sum      sums [NUM_SUMS];

    // Configuration registers
    assign o_cfg_ready = q_status.empty && !back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_x   <= RST_ROW_X;
            r_cfg.row_y   <= RST_ROW_Y;
            r_cfg.row_z   <= RST_ROW_Z;
            r_cfg.centre  <= RST_CENTRE;
            r_cfg.weights <= RST_WEIGHTS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_AFFINE_X: r_cfg.row_x   <= i_cfg_data;
                REG_AFFINE_Y: r_cfg.row_y   <= i_cfg_data;
                REG_AFFINE_Z: r_cfg.row_z   <= i_cfg_data;
                REG_CENTRE:   r_cfg.centre  <= i_cfg_data[CEN_CFG_W-1:0];
                REG_WEIGHTS:  r_cfg.weights <= i_cfg_data;
                default:      r_cfg         <= r_cfg;
            endcase
        end
    end

    wim_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_index_i        (i_index_i),
        .i_index_j        (i_index_j),
        .i_index_k        (i_index_k),
        .i_contrast_index (i_contrast_index),
        .i_intensity      (i_intensity),
        .i_in_mask        (i_in_mask),
        .i_sample_finite  (i_sample_finite),
        .i_last_voxel     (i_last_voxel),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_item           (push_item)
    );

    wim_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    wim_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_head      (head_item),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sums      (sums)
    );

    // Result fields in output order
    assign o_mass_sum  = sums[0];
    assign o_first_x   = sums[1];
    assign o_first_y   = sums[2];
    assign o_first_z   = sums[3];
    assign o_second_xy = sums[4];
    assign o_second_yz = sums[5];
    assign o_second_xz = sums[6];
    assign o_second_xx = sums[7];
    assign o_second_yy = sums[8];
    assign o_second_zz = sums[9];

endmodule

/* sv/wim_front.sv */
// wim_front: input beat acceptance and sample classification.
// Drops skipped samples that carry no last marker. Depends on wim_pkg.

module wim_front
    import wim_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [INDEX_BITS-1:0]      i_index_i,
    input  logic [INDEX_BITS-1:0]      i_index_j,
    input  logic [INDEX_BITS-1:0]      i_index_k,
    input  logic [CONTRAST_W-1:0]      i_contrast_index,
    input  logic signed [INTENS_W-1:0] i_intensity,
    input  logic                       i_in_mask,
    input  logic                       i_sample_finite,
    input  logic                       i_last_voxel,
    input  t_q_status                  i_q_status,
    output logic                       o_push,
    output t_item                      o_item
);

    logic take;
    logic accept;

    // Classify: a sample counts only if masked in, finite and of a known contrast
    always_comb begin
        take = i_in_mask && i_sample_finite && (int'(i_contrast_index) < MAX_CONTRASTS);
    end

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    // Only items that change the sums or close the image go to the back end
    assign o_push = accept && (take || i_last_voxel);

    always_comb begin
        o_item.idx_i     = i_index_i;
        o_item.idx_j     = i_index_j;
        o_item.idx_k     = i_index_k;
        o_item.contrast  = i_contrast_index;
        o_item.intensity = i_intensity;
        o_item.take      = take;
        o_item.last      = i_last_voxel;
    end

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_status.full)
        else $error("item pushed into a full queue");

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_in_valid && o_in_ready))
        else $error("item pushed without an accepted beat");

endmodule

/* sv/wim_queue.sv */
// wim_queue: short item queue between the front and the back end.
// Register-based, one write and one read port. Depends on wim_pkg.

module wim_queue
    import wim_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && o_status.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

endmodule

/* sv/wim_back.sv */
// wim_back: coordinate, weighting and product pipeline, saturating moment
// accumulators and result register. Depends on wim_pkg.

module wim_back
    import wim_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_status i_q_status,
    input  t_item     i_head,
    output logic      o_pop,
    output logic      o_busy,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_sum      o_sums [NUM_SUMS]
);

    logic adv;

    // Stage control
    logic r_vld  [1:NUM_STAGES];
    logic r_take [1:NUM_STAGES];
    logic r_last [1:NUM_STAGES];

    // Stage 1: raw coordinate sums and weighted intensity
    logic signed [CSUM_W-1:0]  r1_csum [NUM_AXES];
    logic signed [WPROD_W-1:0] r1_wprod;
    logic signed [CSUM_W-1:0]  n1_csum [NUM_AXES];
    logic signed [WPROD_W-1:0] n1_wprod;
    logic [FIELD_W-1:0]        weight;
    logic signed [FIELD_W:0]   weight_s;

    // Stage 2: coordinates, centred coordinates, weighted value
    logic signed [CRD_W-1:0]   r2_x   [NUM_AXES];
    logic signed [CEN_W-1:0]   r2_cen [NUM_AXES];
    logic signed [V_W-1:0]     r2_v;
    logic signed [CRD_W-1:0]   n2_x   [NUM_AXES];
    logic signed [CEN_W-1:0]   n2_cen [NUM_AXES];
    logic signed [V_W-1:0]     n2_v;
    logic signed [CSUM_W-1:0]  crd_rnd [NUM_AXES];
    logic signed [CSUM_W-1:0]  crd_sh  [NUM_AXES];
    logic signed [FIELD_W-1:0] offs    [NUM_AXES];
    logic signed [FIELD_W-1:0] ctr     [NUM_AXES];
    logic signed [WPROD_W-1:0] v_rnd;
    logic signed [WPROD_W-1:0] v_sh;
    logic [CFG_W-1:0]          rows    [NUM_AXES];

    // Stage 3: first-moment terms and coordinate pair products
    logic signed [FIRST_W-1:0] r3_first [NUM_AXES];
    logic signed [PP_W-1:0]    r3_pair  [NUM_PAIRS];
    logic signed [V_W-1:0]     r3_v;
    logic signed [FIRST_W-1:0] n3_first [NUM_AXES];
    logic signed [PP_W-1:0]    n3_pair  [NUM_PAIRS];

    // Stage 4: partial products of pair times value
    logic signed [PLO_W-1:0]   r4_lo    [NUM_PAIRS];
    logic signed [PHI_W-1:0]   r4_hi    [NUM_PAIRS];
    logic signed [FIRST_W-1:0] r4_first [NUM_AXES];
    logic signed [V_W-1:0]     r4_v;
    logic signed [PLO_W-1:0]   n4_lo    [NUM_PAIRS];
    logic signed [PHI_W-1:0]   n4_hi    [NUM_PAIRS];
    logic signed [LO_W:0]      lo_s     [NUM_PAIRS];
    logic signed [HI_W-1:0]    hi_s     [NUM_PAIRS];

    // Stage 5: terms at 64 bits, pair terms clamped
    t_sum                      r5_term  [NUM_SUMS];
    t_sum                      n5_term  [NUM_SUMS];
    logic signed [WIDE_W-1:0]  comb     [NUM_PAIRS];

    // Accumulators and result register
    t_sum r_sum [NUM_SUMS];
    t_sum n_sum [NUM_SUMS];
    t_sum r_out [NUM_SUMS];
    logic r_out_valid;

    // The pipeline moves whenever the result register can take a new result
    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = adv && !i_q_status.empty;

    always_comb begin
        o_busy = 1'b0;
        for (int s = 1; s <= NUM_STAGES; s++) begin
            o_busy = o_busy || r_vld[s];
        end
    end

    // Stage valid and flag shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NUM_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[1] <= o_pop;
            for (int s = 2; s <= NUM_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_take[1] <= i_head.take;
            r_last[1] <= i_head.last;
            for (int s = 2; s <= NUM_STAGES; s++) begin
                r_take[s] <= r_take[s-1];
                r_last[s] <= r_last[s-1];
            end
        end
    end

    // Stage 1 logic
    always_comb begin
        weight   = i_cfg.weights[i_head.contrast*FIELD_W +: FIELD_W];
        weight_s = {1'b0, weight};
        n1_wprod = i_head.intensity * weight_s;
        n1_csum[AXIS_X] = coord_sum(i_cfg.row_x, i_head.idx_i, i_head.idx_j, i_head.idx_k);
        n1_csum[AXIS_Y] = coord_sum(i_cfg.row_y, i_head.idx_i, i_head.idx_j, i_head.idx_k);
        n1_csum[AXIS_Z] = coord_sum(i_cfg.row_z, i_head.idx_i, i_head.idx_j, i_head.idx_k);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_csum  <= n1_csum;
            r1_wprod <= n1_wprod;
        end
    end

    // Stage 2 logic: round half up to quarter-mm, add offset, subtract centre
    always_comb begin
        rows[AXIS_X] = i_cfg.row_x;
        rows[AXIS_Y] = i_cfg.row_y;
        rows[AXIS_Z] = i_cfg.row_z;
        for (int a = 0; a < NUM_AXES; a++) begin
            offs[a]    = rows[a][CFG_W-1 -: FIELD_W];
            ctr[a]     = i_cfg.centre[a*FIELD_W +: FIELD_W];
            crd_rnd[a] = r1_csum[a] + CSUM_W'(CRD_HALF);
            crd_sh[a]  = crd_rnd[a] >>> CRD_SH;
            n2_x[a]    = CRD_W'(crd_sh[a]) + CRD_W'(offs[a]);
            n2_cen[a]  = CEN_W'(n2_x[a]) - CEN_W'(ctr[a]);
        end
        v_rnd = r1_wprod + WPROD_W'(V_HALF);
        v_sh  = v_rnd >>> V_SH;
        n2_v  = V_W'(v_sh);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_x   <= n2_x;
            r2_cen <= n2_cen;
            r2_v   <= n2_v;
        end
    end

    // Stage 3 logic
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n3_first[a] = r2_x[a] * r2_v;
        end
        for (int p = 0; p < NUM_PAIRS; p++) begin
            n3_pair[p] = r2_cen[PAIR_A[p]] * r2_cen[PAIR_B[p]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_first <= n3_first;
            r3_pair  <= n3_pair;
            r3_v     <= r2_v;
        end
    end

    // Stage 4 logic: pair product split into halves times value
    always_comb begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
            lo_s[p]  = {1'b0, r3_pair[p][LO_W-1:0]};
            hi_s[p]  = r3_pair[p][PP_W-1:LO_W];
            n4_lo[p] = lo_s[p] * r3_v;
            n4_hi[p] = hi_s[p] * r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_lo    <= n4_lo;
            r4_hi    <= n4_hi;
            r4_first <= r3_first;
            r4_v     <= r3_v;
        end
    end

    // Stage 5 logic: widen mass and first-moment terms, recombine pair halves and clamp to 64 bits
    always_comb begin
        n5_term[0] = SUM_W'(r4_v);
        for (int a = 0; a < NUM_AXES; a++) begin
            n5_term[1+a] = SUM_W'(r4_first[a]);
        end
        for (int p = 0; p < NUM_PAIRS; p++) begin
            comb[p] = (WIDE_W'(r4_hi[p]) <<< LO_W) + WIDE_W'(r4_lo[p]);
            n5_term[1+NUM_AXES+p] = sat64(comb[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_term <= n5_term;
        end
    end

    // Saturating accumulation
    always_comb begin
        for (int n = 0; n < NUM_SUMS; n++) begin
            n_sum[n] = r_take[NUM_STAGES] ? sat_add(r_sum[n], r5_term[n]) : r_sum[n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NUM_SUMS; n++) begin
                r_sum[n] <= '0;
            end
        end else if (adv && r_vld[NUM_STAGES]) begin
            for (int n = 0; n < NUM_SUMS; n++) begin
                r_sum[n] <= r_last[NUM_STAGES] ? '0 : n_sum[n];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (adv && r_vld[NUM_STAGES] && r_last[NUM_STAGES]) begin
            r_out <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_vld[NUM_STAGES] && r_last[NUM_STAGES]) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sums      = r_out;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[NUM_STAGES] && r_last[NUM_STAGES]))
        else $error("result raised without a last item");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[NUM_STAGES] && r_last[NUM_STAGES])
            |=> (r_sum[0] == '0 && r_sum[NUM_SUMS-1] == '0))
        else $error("sums not cleared after last item");

    a_skip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[NUM_STAGES] && !r_take[NUM_STAGES] && !r_last[NUM_STAGES])
            |=> ($stable(r_sum[0]) && $stable(r_sum[NUM_SUMS-1])))
        else $error("skipped sample changed the sums");

endmodule
